// ----- hdl/rjt_pkg.sv -----
// rjt_pkg: shared types and codes for the round-trip time and jitter tracker
// used by rjt_divider and rtt_jitter_tracker; no dependencies
`timescale 1ns / 1ps

package rjt_pkg;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_REPLY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // sequencer of the top level
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOLD_HI,
      ST_FOLD_LO,
      ST_RECIP,
      ST_REM,
      ST_READ,
      ST_CHECK,
      ST_PUSH,
      ST_JPUSH,
      ST_RTT_GO,
      ST_RTT_WAIT,
      ST_JIT_GO,
      ST_JIT_WAIT,
      ST_DONE
   } state_type;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   localparam int SAMPLE_W = 32;

endpackage

// ----- hdl/rjt_divider.sv -----
// rjt_divider: restoring radix-2 divider, one quotient bit per cycle
// depends on rjt_pkg (div_status_type)
`timescale 1ns / 1ps

module rjt_divider #(
   parameter int DIVIDEND_W = 39,
   parameter int DIVISOR_W  = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIVIDEND_W-1:0]      dividend,
   input  logic [DIVISOR_W-1:0]       divisor,
   output rjt_pkg::div_status_type    status,
   output logic [DIVIDEND_W-1:0]      quotient
);
   import rjt_pkg::*;

   localparam int CW = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff : shifted;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- hdl/rtt_jitter_tracker.sv -----
// rtt_jitter_tracker: ping round-trip time, min/max and windowed rtt/jitter means
// depends on rjt_pkg and rjt_divider
//
// usage:
//  - req channel: one transaction per ping event; req_tuser is the kind (send,
//    reply, clear min/max), req_tdata holds sequence number and timestamp.
//  - rsp channel: exactly one transaction per request, in order; rsp_tuser
//    flags a matched reply, rsp_tdata holds current rtt, mean rtt, mean
//    jitter, min and max.
//  - one request at a time: req_tready is high only while the sequencer idles.
//    a send, clear or unused kind passes ST_READ and ST_DONE, an unmatched
//    reply also ST_CHECK; ST_DONE loads the result. a matched reply adds
//    ST_PUSH, ST_JPUSH and two divisions on the one serial divider that forms
//    both means one quotient bit per cycle, dividend 32 + clog2(window+1) bits
//    (39 for 64-entry windows); the first matched reply has no jitter sample
//    and skips ST_JPUSH and its division. with a slot count not a power of
//    two the slot index is reduced by two folds and a reciprocal multiply.
//  - the result sits in an output register: a stalled receiver holds the
//    result while the next request is accepted and worked on; the sequencer
//    waits only when it has a new result and the old one is still not taken.
//  - reset clears the pending slots, both windows and all statistics; min
//    reads all ones and max zero until the first matched reply.
`timescale 1ns / 1ps

module rtt_jitter_tracker #(
   parameter int RTT_WINDOW    = 64,
   parameter int JITTER_WINDOW = 64,
   parameter int PENDING_SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sequence_number [31:0], timestamp_us [63:32]
   input  logic [63:0]  req_tdata,
   // operation [1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // current_rtt_us [31:0], average_rtt_us [63:32], average_jitter_us [95:64],
   // min_rtt_us [127:96], max_rtt_us [159:128]
   output logic [159:0] rsp_tdata,
   // matched [0]
   output logic [0:0]   rsp_tuser
);
   import rjt_pkg::*;

   localparam int SLW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
   localparam bit SLOT_POW2 = ((PENDING_SLOTS & (PENDING_SLOTS - 1)) == 0);
   localparam logic [SLW-1:0] SLOT_MASK = SLW'(PENDING_SLOTS - 1);
   localparam int RHW = (RTT_WINDOW > 1) ? $clog2(RTT_WINDOW) : 1;
   localparam int JHW = (JITTER_WINDOW > 1) ? $clog2(JITTER_WINDOW) : 1;
   localparam int RFW = $clog2(RTT_WINDOW + 1);
   localparam int JFW = $clog2(JITTER_WINDOW + 1);
   localparam int RTW = SAMPLE_W + RFW;
   localparam int JTW = SAMPLE_W + JFW;
   localparam int DW  = (RTW > JTW) ? RTW : JTW;
   localparam int DVW = (RFW > JFW) ? RFW : JFW;

   // slot = seq mod slots without a divider: fold the upper half twice with
   // 2^16 mod slots, then take the quotient of the 17-bit rest by reciprocal
   localparam int FOLD_C  = (1 << 16) % PENDING_SLOTS;
   localparam int RECIP_M = ((1 << 25) + PENDING_SLOTS - 1) / PENDING_SLOTS;
   localparam logic [7:0]  FOLD_K  = 8'(FOLD_C);
   localparam logic [25:0] RECIP_K = 26'(RECIP_M);
   localparam logic [8:0]  SLOT_K  = 9'(PENDING_SLOTS);

   state_type state_ff, state_in;

   op_type                op_ff;
   logic [SAMPLE_W-1:0]   seq_ff;
   logic [SAMPLE_W-1:0]   ts_ff;
   logic [SLW-1:0]        slot_ff;
   logic [PENDING_SLOTS-1:0] valid_ff;

   logic [23:0]           fold_ff;
   logic [16:0]           quot_ff;
   logic [23:0]           fold_hi;
   logic [23:0]           fold_lo;
   logic [41:0]           recip_prod;
   logic [16:0]           slot_rem;

   logic [SAMPLE_W-1:0]   pend_time_mem [PENDING_SLOTS];
   logic [SAMPLE_W-1:0]   pend_tag_mem  [PENDING_SLOTS];
   logic [SAMPLE_W-1:0]   time_rd_ff;
   logic [SAMPLE_W-1:0]   tag_rd_ff;

   logic [SAMPLE_W-1:0]   rtt_mem [RTT_WINDOW];
   logic [SAMPLE_W-1:0]   rtt_old_ff;
   logic [RFW-1:0]        rtt_fill_ff;
   logic [RHW-1:0]        rtt_head_ff;
   logic [RTW-1:0]        rtt_total_ff;

   logic [SAMPLE_W-1:0]   jit_mem [JITTER_WINDOW];
   logic [SAMPLE_W-1:0]   jit_old_ff;
   logic [JFW-1:0]        jit_fill_ff;
   logic [JHW-1:0]        jit_head_ff;
   logic [JTW-1:0]        jit_total_ff;

   logic [SAMPLE_W-1:0]   prior_rtt_ff;
   logic                  have_prev_ff;
   logic [SAMPLE_W-1:0]   low_ff;
   logic [SAMPLE_W-1:0]   high_ff;
   logic [SAMPLE_W-1:0]   latest_ff;
   logic [SAMPLE_W-1:0]   mean_rtt_ff;
   logic [SAMPLE_W-1:0]   mean_jit_ff;
   logic [SAMPLE_W-1:0]   rtt_ff;
   logic [SAMPLE_W-1:0]   diff_ff;
   logic                  hit_ff;
   logic                  jit_en_ff;

   logic                  rsp_valid_ff;
   logic [159:0]          rsp_data_ff;
   logic                  rsp_user_ff;

   // sequencer strobes
   logic                  accept;
   logic                  mem_rd_en;
   logic                  pend_wr_en;
   logic                  rtt_wr_en;
   logic                  jit_wr_en;
   logic                  div_start;
   logic                  rsp_load;
   logic                  hit;
   logic                  rtt_full;
   logic                  jit_full;

   logic [DW-1:0]         div_dividend;
   logic [DVW-1:0]        div_divisor;
   div_status_type        div_stat;
   logic [DW-1:0]         div_quotient;

   rjt_divider #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (DVW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_stat),
      .quotient  (div_quotient)
   );

   assign hit      = valid_ff[slot_ff] && (tag_rd_ff == seq_ff);
   assign rtt_full = (rtt_fill_ff == RFW'(RTT_WINDOW));
   assign jit_full = (jit_fill_ff == JFW'(JITTER_WINDOW));

   assign fold_hi    = {8'd0, seq_ff[31:16]} * {16'd0, FOLD_K} + {8'd0, seq_ff[15:0]};
   assign fold_lo    = {16'd0, fold_ff[23:16]} * {16'd0, FOLD_K} + {8'd0, fold_ff[15:0]};
   assign recip_prod = {25'd0, fold_ff[16:0]} * {16'd0, RECIP_K};
   assign slot_rem   = fold_ff[16:0] - quot_ff * {8'd0, SLOT_K};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = SLOT_POW2 ? ST_READ : ST_FOLD_HI;
         end
         ST_FOLD_HI:  state_in = ST_FOLD_LO;
         ST_FOLD_LO:  state_in = ST_RECIP;
         ST_RECIP:    state_in = ST_REM;
         ST_REM:      state_in = ST_READ;
         ST_READ: begin
            state_in = (op_ff == OP_REPLY) ? ST_CHECK : ST_DONE;
         end
         ST_CHECK: begin
            state_in = hit ? ST_PUSH : ST_DONE;
         end
         ST_PUSH: begin
            state_in = have_prev_ff ? ST_JPUSH : ST_RTT_GO;
         end
         ST_JPUSH:    state_in = ST_RTT_GO;
         ST_RTT_GO:   state_in = ST_RTT_WAIT;
         ST_RTT_WAIT: begin
            if (div_stat.done) state_in = jit_en_ff ? ST_JIT_GO : ST_DONE;
         end
         ST_JIT_GO:   state_in = ST_JIT_WAIT;
         ST_JIT_WAIT: begin
            if (div_stat.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      accept       = 1'b0;
      mem_rd_en    = 1'b0;
      pend_wr_en   = 1'b0;
      rtt_wr_en    = 1'b0;
      jit_wr_en    = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         ST_IDLE:   accept = req_tvalid;
         ST_READ: begin
            mem_rd_en  = 1'b1;
            pend_wr_en = (op_ff == OP_SEND);
         end
         ST_PUSH:   rtt_wr_en = 1'b1;
         ST_JPUSH:  jit_wr_en = 1'b1;
         ST_RTT_GO: begin
            div_start    = 1'b1;
            div_dividend = DW'(rtt_total_ff);
            div_divisor  = DVW'(rtt_fill_ff);
         end
         ST_JIT_GO: begin
            div_start    = 1'b1;
            div_dividend = DW'(jit_total_ff);
            div_divisor  = DVW'(jit_fill_ff);
         end
         ST_DONE:   rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   // pending slot memories
   always_ff @(posedge clock) begin
      if (pend_wr_en) begin
         pend_time_mem[slot_ff] <= ts_ff;
         pend_tag_mem[slot_ff]  <= seq_ff;
      end
      if (mem_rd_en) begin
         time_rd_ff <= pend_time_mem[slot_ff];
         tag_rd_ff  <= pend_tag_mem[slot_ff];
      end
   end

   // rtt window memory, oldest entry read ahead of the push
   always_ff @(posedge clock) begin
      if (rtt_wr_en) rtt_mem[rtt_head_ff] <= rtt_ff;
      if (mem_rd_en) rtt_old_ff <= rtt_mem[rtt_head_ff];
   end

   // jitter window memory
   always_ff @(posedge clock) begin
      if (jit_wr_en) jit_mem[jit_head_ff] <= diff_ff;
      if (mem_rd_en) jit_old_ff <= jit_mem[jit_head_ff];
   end

   // control and statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rtt_fill_ff  <= '0;
         rtt_head_ff  <= '0;
         rtt_total_ff <= '0;
         jit_fill_ff  <= '0;
         jit_head_ff  <= '0;
         jit_total_ff <= '0;
         prior_rtt_ff <= '0;
         have_prev_ff <= 1'b0;
         low_ff       <= '1;
         high_ff      <= '0;
         latest_ff    <= '0;
         mean_rtt_ff  <= '0;
         mean_jit_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_READ: begin
               if (op_ff == OP_SEND) valid_ff[slot_ff] <= 1'b1;
               if (op_ff == OP_CLEAR) begin
                  low_ff  <= '1;
                  high_ff <= '0;
               end
            end
            ST_CHECK: begin
               if (hit) begin
                  valid_ff[slot_ff] <= 1'b0;
                  latest_ff         <= ts_ff - time_rd_ff;
                  // drop the oldest entry of a full window before the push
                  if (rtt_full) rtt_total_ff <= rtt_total_ff - RTW'(rtt_old_ff);
                  if (have_prev_ff && jit_full) begin
                     jit_total_ff <= jit_total_ff - JTW'(jit_old_ff);
                  end
               end
            end
            ST_PUSH: begin
               rtt_total_ff <= rtt_total_ff + RTW'(rtt_ff);
               if (!rtt_full) rtt_fill_ff <= rtt_fill_ff + 1'b1;
               rtt_head_ff <= (rtt_head_ff == RHW'(RTT_WINDOW - 1)) ? '0
                                                                 : rtt_head_ff + 1'b1;
               if (rtt_ff < low_ff)  low_ff  <= rtt_ff;
               if (rtt_ff > high_ff) high_ff <= rtt_ff;
               prior_rtt_ff <= rtt_ff;
               have_prev_ff <= 1'b1;
            end
            ST_JPUSH: begin
               jit_total_ff <= jit_total_ff + JTW'(diff_ff);
               if (!jit_full) jit_fill_ff <= jit_fill_ff + 1'b1;
               jit_head_ff <= (jit_head_ff == JHW'(JITTER_WINDOW - 1)) ? '0
                                                                    : jit_head_ff + 1'b1;
            end
            ST_RTT_WAIT: begin
               if (div_stat.done) mean_rtt_ff <= div_quotient[SAMPLE_W-1:0];
            end
            ST_JIT_WAIT: begin
               if (div_stat.done) mean_jit_ff <= div_quotient[SAMPLE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // transaction payload and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_tuser[1:0]);
         seq_ff  <= req_tdata[31:0];
         ts_ff   <= req_tdata[63:32];
         slot_ff <= req_tdata[SLW-1:0] & SLOT_MASK;
         hit_ff  <= 1'b0;
      end
      if (state_ff == ST_FOLD_HI) fold_ff <= fold_hi;
      if (state_ff == ST_FOLD_LO) fold_ff <= fold_lo;
      if (state_ff == ST_RECIP)   quot_ff <= recip_prod[41:25];
      if (state_ff == ST_REM)     slot_ff <= slot_rem[SLW-1:0];
      if (state_ff == ST_CHECK && hit) begin
         rtt_ff <= ts_ff - time_rd_ff;
         hit_ff <= 1'b1;
      end
      if (state_ff == ST_PUSH) begin
         diff_ff   <= (rtt_ff >= prior_rtt_ff) ? rtt_ff - prior_rtt_ff
                                               : prior_rtt_ff - rtt_ff;
         jit_en_ff <= have_prev_ff;
      end
      if (rsp_load) begin
         rsp_user_ff <= hit_ff;
         rsp_data_ff <= {high_ff, low_ff, mean_jit_ff, mean_rtt_ff, latest_ff};
      end
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   // a matched reply always lies between the min and max it just updated
   a_match_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[127:96] <= rsp_tdata[31:0]) && (rsp_tdata[31:0] <= rsp_tdata[159:128]))
      else $error("matched rtt outside min/max");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_rtt_bounds: assert property (@(posedge clock) disable iff (reset)
      (rtt_fill_ff <= RFW'(RTT_WINDOW)) && (rtt_head_ff <= RHW'(RTT_WINDOW - 1)))
      else $error("rtt window fill or head out of range");

   a_empty_before_first: assert property (@(posedge clock) disable iff (reset)
      !have_prev_ff |-> (rtt_fill_ff == '0) && (jit_fill_ff == '0))
      else $error("window filled before first matched reply");

   a_divide_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RTT_GO) |-> (rtt_fill_ff != '0))
      else $error("mean taken over empty rtt window");

endmodule
